@@ hw/rtl/atd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package atd_pkg;

	// fraction bits of the quaternion outputs and of the normalized entries
	localparam int QUAT_FRAC_BITS = 30;
	localparam int NORM_FRAC = 30;

	typedef struct packed {
		logic signed [31:0] axis0_x;
		logic signed [31:0] axis0_y;
		logic signed [31:0] axis0_z;
		logic signed [31:0] axis1_x;
		logic signed [31:0] axis1_y;
		logic signed [31:0] axis1_z;
		logic signed [31:0] axis2_x;
		logic signed [31:0] axis2_y;
		logic signed [31:0] axis2_z;
		logic signed [31:0] move_x;
		logic signed [31:0] move_y;
		logic signed [31:0] move_z;
	} mat_t;

	typedef enum logic [1:0] {
		FAULT_NONE      = 2'd0,
		FAULT_ZERO_AXIS = 2'd1,
		FAULT_TRACE     = 2'd2
	} fault_t;

	typedef struct packed {
		logic signed [31:0] out_move_x;
		logic signed [31:0] out_move_y;
		logic signed [31:0] out_move_z;
		logic [31:0]        scale_x;
		logic [31:0]        scale_y;
		logic [31:0]        scale_z;
		logic signed [31:0] quat_x;
		logic signed [31:0] quat_y;
		logic signed [31:0] quat_z;
		logic signed [31:0] quat_w;
		fault_t             fault;
	} trs_t;

	// digit-by-digit square root state: two radicand bits per step
	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] src;
	} sqrt_t;

	// restoring division state: quo holds the pending numerator bits, then the quotient
	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] quo;
		logic [31:0] den;
	} div_t;

	function automatic sqrt_t sqrt_step(input sqrt_t x);
		sqrt_t       y;
		logic [35:0] acc;
		logic [35:0] trial;
		acc = {x.rem, x.src[63:62]};
		trial = {2'b00, x.root, 2'b01};
		y.src = {x.src[61:0], 2'b00};
		if (acc >= trial) begin
			y.rem = 34'(acc - trial);
			y.root = {x.root[30:0], 1'b1};
		end else begin
			y.rem = acc[33:0];
			y.root = {x.root[30:0], 1'b0};
		end
		return y;
	endfunction

	function automatic div_t div_step(input div_t x);
		div_t        y;
		logic [32:0] acc;
		logic [32:0] dd;
		acc = {x.rem, x.quo[30]};
		dd = {1'b0, x.den};
		y.den = x.den;
		if (acc >= dd) begin
			y.rem = 32'(acc - dd);
			y.quo = {x.quo[29:0], 1'b1};
		end else begin
			y.rem = acc[31:0];
			y.quo = {x.quo[29:0], 1'b0};
		end
		return y;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/affine_matrix_trs_decompose.sv @@
`timescale 1ns / 1ps
`default_nettype none
// affine transform splitter: translation, per-axis scale, rotation quaternion
// input channel mat (mat_valid / mat_stall): three basis axes and a translation,
//   Q16.16 signed; a transaction is taken when mat_valid is high and mat_stall low
// output channel trs (trs_valid / trs_stall): translation passed through, scales
//   as unsigned lengths of the axes, quaternion in Q2.30 and a fault code
// throughput: one transaction per cycle while trs_stall does not hold the pipe, every stage is a register stage
// pipeline: the path from acceptance to trs_valid runs through the chain of
//   5 normalize steps, a 32-step square root for the axis lengths, a 31-step
//   divider for the axis entries, a 32-step square root of the trace and a
//   31-step divider for the quaternion terms
// stall: when a result waits under trs_stall the whole pipe holds and mat_stall
//   is raised in the same cycle; nothing is dropped or repeated
// reset: arst_n clears all stage valid bits, the pipe comes up empty
// faults: a zero axis gives code 1, a non-positive trace code 2 (zero axis wins);
//   either way the quaternion is the identity and scales are still reported
module affine_matrix_trs_decompose (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          mat_valid,
	output logic          mat_stall,
	input  atd_pkg::mat_t mat,
	output logic          trs_valid,
	input  logic          trs_stall,
	output atd_pkg::trs_t trs
);

	// stage map
	localparam int ST_IN       = 1;
	localparam int ST_MAG      = ST_IN + 1;
	localparam int ST_SQR      = ST_MAG + 1;
	localparam int ST_SUM      = ST_SQR + 1;
	localparam int NRM_STEPS   = 5;
	localparam int ST_NRM_END  = ST_SUM + NRM_STEPS;
	localparam int SQRT_STEPS  = 32;
	localparam int ST_RT0      = ST_NRM_END + 1;
	localparam int ST_RT_END   = ST_NRM_END + SQRT_STEPS;
	localparam int DIV_STEPS   = 31;
	localparam int ST_DIVI     = ST_RT_END + 1;
	localparam int ST_DIV_END  = ST_DIVI + DIV_STEPS;
	// entries at +1, branch at +2, trace prep at +3
	localparam int ST_QPREP    = ST_DIV_END + 3;
	localparam int ST_R0       = ST_QPREP + 1;
	localparam int ST_R_END    = ST_QPREP + SQRT_STEPS;
	localparam int ST_QDIVI    = ST_R_END + 1;
	localparam int ST_QDIV_END = ST_QDIVI + DIV_STEPS;
	localparam int ST_OUT      = ST_QDIV_END + 1;

	localparam logic signed [33:0] ONE_Q30 = 34'sh0_4000_0000;

	// one enable for the whole pipe: it holds only while a result is stalled
	logic              en;
	logic [ST_OUT:1]   vld_s;

	assign en        = !(vld_s[ST_OUT] && trs_stall);
	assign mat_stall = !en;
	assign trs_valid = vld_s[ST_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[ST_OUT-1:1], mat_valid};
		end
	end

	// payload stages
	logic [8:0][31:0] a_s1;
	logic [2:0][31:0] move_s  [ST_IN:ST_OUT-1];
	logic [8:0][31:0] mag_s   [ST_MAG:ST_RT_END];
	logic [8:0]       neg_s   [ST_MAG:ST_DIV_END];
	logic [8:0][63:0] prod_s3;
	logic             zf_s    [ST_SQR:ST_OUT-1];
	logic [2:0][63:0] sq_s    [ST_SUM:ST_NRM_END];
	logic [2:0][63:0] nv_s    [ST_SUM:ST_NRM_END];
	logic [2:0][4:0]  sh_s    [ST_SUM:ST_RT_END];
	atd_pkg::sqrt_t   rt_s    [ST_RT0:ST_RT_END][6];
	logic [2:0][31:0] scale_s [ST_DIVI:ST_OUT-1];
	atd_pkg::div_t    dv_s    [ST_DIVI:ST_DIV_END][9];
	logic signed [31:0] ent_s74 [9];
	logic signed [33:0] t_s75;
	logic signed [33:0] q_s75 [4];
	logic [63:0]      rsrc_s76;
	logic             tf_s    [ST_QPREP:ST_OUT-1];
	logic [3:0]       qneg_s  [ST_QPREP:ST_OUT-1];
	logic [3:0][63:0] qn_s    [ST_QPREP:ST_R_END];
	atd_pkg::sqrt_t   rr_s    [ST_R0:ST_R_END];
	logic [3:0]       qsat_s  [ST_QDIVI:ST_OUT-1];
	atd_pkg::div_t    qd_s    [ST_QDIVI:ST_QDIV_END][4];
	atd_pkg::trs_t    trs_s141;

	// combinational parts of single stages
	logic [8:0][31:0]   mag_c;
	logic [2:0][63:0]   sum_c;
	atd_pkg::sqrt_t     rti_c [6];
	atd_pkg::div_t      dvi_c [9];
	logic signed [33:0] e_c [9];
	logic signed [33:0] t_c;
	logic signed [33:0] q_c [4];
	logic [3:0][33:0]   qmag_c;
	logic [63:0]        qlim_c;
	logic [3:0]         qsat_c;
	atd_pkg::div_t      qdi_c [4];
	atd_pkg::sqrt_t     rri_c;
	logic [3:0][31:0]   quat_c;
	logic [62:0]        nm_c [9];
	logic [62:0]        qnum_c [4];

	always_comb begin
		// magnitudes of the raw axis values
		for (int j = 0; j < 9; j++) begin
			mag_c[j] = a_s1[j][31] ? (~a_s1[j] + 32'd1) : a_s1[j];
		end
		// squared lengths, at most three times 2^62
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = prod_s3[3*i] + prod_s3[3*i+1] + prod_s3[3*i+2];
		end
		// square root lanes: 0..2 raw lengths, 3..5 lengths of the normalized squares
		for (int i = 0; i < 3; i++) begin
			rti_c[i].rem = '0;
			rti_c[i].root = '0;
			rti_c[i].src = sq_s[ST_NRM_END][i];
			rti_c[3+i].rem = '0;
			rti_c[3+i].root = '0;
			rti_c[3+i].src = nv_s[ST_NRM_END][i];
		end
		// entry numerators: |a| << s << 30, below 2^62
		for (int j = 0; j < 9; j++) begin
			nm_c[j] = (63'(mag_s[ST_RT_END][j]) << sh_s[ST_RT_END][j/3]) << atd_pkg::NORM_FRAC;
			dvi_c[j].rem = nm_c[j][62:31];
			dvi_c[j].quo = nm_c[j][30:0];
			dvi_c[j].den = rt_s[ST_RT_END][3 + j/3].root;
		end
		// four-branch trace selection, entry (r, c) is e_c[3r+c]
		for (int j = 0; j < 9; j++) begin
			e_c[j] = 34'(ent_s74[j]);
		end
		if (e_c[8] < 0) begin
			if (e_c[0] > e_c[4]) begin
				t_c = ONE_Q30 + e_c[0] - e_c[4] - e_c[8];
				q_c[0] = t_c;
				q_c[1] = e_c[1] + e_c[3];
				q_c[2] = e_c[6] + e_c[2];
				q_c[3] = e_c[5] - e_c[7];
			end else begin
				t_c = ONE_Q30 - e_c[0] + e_c[4] - e_c[8];
				q_c[0] = e_c[1] + e_c[3];
				q_c[1] = t_c;
				q_c[2] = e_c[5] + e_c[7];
				q_c[3] = e_c[6] - e_c[2];
			end
		end else begin
			if (e_c[0] < -e_c[4]) begin
				t_c = ONE_Q30 - e_c[0] - e_c[4] + e_c[8];
				q_c[0] = e_c[6] + e_c[2];
				q_c[1] = e_c[5] + e_c[7];
				q_c[2] = t_c;
				q_c[3] = e_c[1] - e_c[3];
			end else begin
				t_c = ONE_Q30 + e_c[0] + e_c[4] + e_c[8];
				q_c[0] = e_c[5] - e_c[7];
				q_c[1] = e_c[6] - e_c[2];
				q_c[2] = e_c[1] - e_c[3];
				q_c[3] = t_c;
			end
		end
		for (int i = 0; i < 4; i++) begin
			qmag_c[i] = q_s75[i][33] ? 34'(-q_s75[i]) : 34'(q_s75[i]);
		end
		rri_c.rem = '0;
		rri_c.root = '0;
		rri_c.src = rsrc_s76;
		// a quotient of 2^31 or more saturates, so the divider only sees what fits
		qlim_c = {1'b0, rr_s[ST_R_END].root, 31'b0};
		for (int i = 0; i < 4; i++) begin
			qsat_c[i] = qn_s[ST_R_END][i] >= qlim_c;
			qnum_c[i] = qsat_c[i] ? 63'd0 : qn_s[ST_R_END][i][62:0];
			qdi_c[i].rem = qnum_c[i][62:31];
			qdi_c[i].quo = qnum_c[i][30:0];
			qdi_c[i].den = rr_s[ST_R_END].root;
		end
		// signed, saturated quaternion terms, truncated toward zero
		for (int i = 0; i < 4; i++) begin
			if (qsat_s[ST_QDIV_END][i]) begin
				quat_c[i] = qneg_s[ST_QDIV_END][i] ? 32'h8000_0000 : 32'h7fff_ffff;
			end else if (qneg_s[ST_QDIV_END][i]) begin
				quat_c[i] = 32'd0 - {1'b0, qd_s[ST_QDIV_END][i].quo};
			end else begin
				quat_c[i] = {1'b0, qd_s[ST_QDIV_END][i].quo};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// input registers
			a_s1 <= {mat.axis2_z, mat.axis2_y, mat.axis2_x,
				mat.axis1_z, mat.axis1_y, mat.axis1_x,
				mat.axis0_z, mat.axis0_y, mat.axis0_x};
			move_s[ST_IN] <= {mat.move_z, mat.move_y, mat.move_x};
			for (int k = ST_IN + 1; k < ST_OUT; k++) begin
				move_s[k] <= move_s[k-1];
			end

			// magnitudes and signs
			mag_s[ST_MAG] <= mag_c;
			for (int j = 0; j < 9; j++) begin
				neg_s[ST_MAG][j] <= a_s1[j][31];
			end
			for (int k = ST_MAG + 1; k <= ST_RT_END; k++) begin
				mag_s[k] <= mag_s[k-1];
			end
			for (int k = ST_MAG + 1; k <= ST_DIV_END; k++) begin
				neg_s[k] <= neg_s[k-1];
			end

			// squares and the zero-axis flag
			for (int j = 0; j < 9; j++) begin
				prod_s3[j] <= 64'(mag_s[ST_MAG][j]) * 64'(mag_s[ST_MAG][j]);
			end
			zf_s[ST_SQR] <= (mag_s[ST_MAG][2:0] == '0) || (mag_s[ST_MAG][5:3] == '0)
				|| (mag_s[ST_MAG][8:6] == '0);
			for (int k = ST_SQR + 1; k < ST_OUT; k++) begin
				zf_s[k] <= zf_s[k-1];
			end

			// squared lengths, then leading zero pairs shifted out in halving widths
			sq_s[ST_SUM] <= sum_c;
			nv_s[ST_SUM] <= sum_c;
			sh_s[ST_SUM] <= '0;
			for (int k = 0; k < NRM_STEPS; k++) begin
				sq_s[ST_SUM+k+1] <= sq_s[ST_SUM+k];
				for (int i = 0; i < 3; i++) begin
					if ((nv_s[ST_SUM+k][i] >> (64 - (2 << (NRM_STEPS-1-k)))) == 64'd0) begin
						nv_s[ST_SUM+k+1][i] <= nv_s[ST_SUM+k][i] << (2 << (NRM_STEPS-1-k));
						sh_s[ST_SUM+k+1][i] <= sh_s[ST_SUM+k][i] | 5'(1 << (NRM_STEPS-1-k));
					end else begin
						nv_s[ST_SUM+k+1][i] <= nv_s[ST_SUM+k][i];
						sh_s[ST_SUM+k+1][i] <= sh_s[ST_SUM+k][i];
					end
				end
			end
			for (int k = ST_NRM_END + 1; k <= ST_RT_END; k++) begin
				sh_s[k] <= sh_s[k-1];
			end

			// length square roots
			for (int i = 0; i < 6; i++) begin
				rt_s[ST_RT0][i] <= atd_pkg::sqrt_step(rti_c[i]);
				for (int k = ST_RT0 + 1; k <= ST_RT_END; k++) begin
					rt_s[k][i] <= atd_pkg::sqrt_step(rt_s[k-1][i]);
				end
			end
			// raw lengths stay below 2^32, no saturation needed
			for (int i = 0; i < 3; i++) begin
				scale_s[ST_DIVI][i] <= rt_s[ST_RT_END][i].root;
			end
			for (int k = ST_DIVI + 1; k < ST_OUT; k++) begin
				scale_s[k] <= scale_s[k-1];
			end

			// entry dividers
			for (int j = 0; j < 9; j++) begin
				dv_s[ST_DIVI][j] <= dvi_c[j];
				for (int k = ST_DIVI + 1; k <= ST_DIV_END; k++) begin
					dv_s[k][j] <= atd_pkg::div_step(dv_s[k-1][j]);
				end
			end

			// signed normalized entries
			for (int j = 0; j < 9; j++) begin
				ent_s74[j] <= neg_s[ST_DIV_END][j] ? (32'sd0 - 32'(dv_s[ST_DIV_END][j].quo))
					: 32'(dv_s[ST_DIV_END][j].quo);
			end

			// trace branch
			t_s75 <= t_c;
			for (int i = 0; i < 4; i++) begin
				q_s75[i] <= q_c[i];
			end

			// trace check, square root source and scaled term magnitudes
			tf_s[ST_QPREP] <= t_s75 <= 34'sd0;
			rsrc_s76 <= {t_s75, 30'b0};
			for (int i = 0; i < 4; i++) begin
				qneg_s[ST_QPREP][i] <= q_s75[i][33];
				qn_s[ST_QPREP][i] <= 64'(qmag_c[i]) << (atd_pkg::QUAT_FRAC_BITS - 1);
			end
			for (int k = ST_QPREP + 1; k < ST_OUT; k++) begin
				tf_s[k] <= tf_s[k-1];
				qneg_s[k] <= qneg_s[k-1];
			end
			for (int k = ST_QPREP + 1; k <= ST_R_END; k++) begin
				qn_s[k] <= qn_s[k-1];
			end

			// trace square root
			rr_s[ST_R0] <= atd_pkg::sqrt_step(rri_c);
			for (int k = ST_R0 + 1; k <= ST_R_END; k++) begin
				rr_s[k] <= atd_pkg::sqrt_step(rr_s[k-1]);
			end

			// quaternion dividers
			qsat_s[ST_QDIVI] <= qsat_c;
			for (int k = ST_QDIVI + 1; k < ST_OUT; k++) begin
				qsat_s[k] <= qsat_s[k-1];
			end
			for (int i = 0; i < 4; i++) begin
				qd_s[ST_QDIVI][i] <= qdi_c[i];
				for (int k = ST_QDIVI + 1; k <= ST_QDIV_END; k++) begin
					qd_s[k][i] <= atd_pkg::div_step(qd_s[k-1][i]);
				end
			end

			// output register
			trs_s141.out_move_x <= move_s[ST_OUT-1][0];
			trs_s141.out_move_y <= move_s[ST_OUT-1][1];
			trs_s141.out_move_z <= move_s[ST_OUT-1][2];
			trs_s141.scale_x <= scale_s[ST_OUT-1][0];
			trs_s141.scale_y <= scale_s[ST_OUT-1][1];
			trs_s141.scale_z <= scale_s[ST_OUT-1][2];
			if (zf_s[ST_OUT-1] || tf_s[ST_OUT-1]) begin
				// identity quaternion on either fault
				trs_s141.quat_x <= '0;
				trs_s141.quat_y <= '0;
				trs_s141.quat_z <= '0;
				trs_s141.quat_w <= 32'sd1 <<< atd_pkg::QUAT_FRAC_BITS;
				trs_s141.fault <= zf_s[ST_OUT-1] ? atd_pkg::FAULT_ZERO_AXIS
					: atd_pkg::FAULT_TRACE;
			end else begin
				trs_s141.quat_x <= quat_c[0];
				trs_s141.quat_y <= quat_c[1];
				trs_s141.quat_z <= quat_c[2];
				trs_s141.quat_w <= quat_c[3];
				trs_s141.fault <= atd_pkg::FAULT_NONE;
			end
		end
	end

	assign trs = trs_s141;

endmodule

`default_nettype wire
